@@ design/ibu_pkg.sv @@
package ibu_pkg;

  localparam int MAX_BINS = 64;
  localparam int IDX_W    = $clog2(MAX_BINS);
  localparam int CNT_W    = $clog2(MAX_BINS) + 1;
  localparam int K_DEPTH  = MAX_BINS * MAX_BINS;
  localparam int EFF_W    = 32 + IDX_W + 1;

  // configuration register indexes (byte address bit 2)
  localparam logic REG_ITERATIONS = 1'b0;
  localparam logic REG_BINS       = 1'b1;

  localparam logic [7:0] ITER_RESET = 8'd4;
  localparam logic [6:0] BINS_RESET = 7'd64;

  typedef enum logic [1:0] {
    FUNC_RESP  = 2'd0,
    FUNC_MEAS  = 2'd1,
    FUNC_PRIOR = 2'd2,
    FUNC_START = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_COPY,
    ST_FOLD,
    ST_FDRAIN,
    ST_FDIV,
    ST_UPD,
    ST_UDRAIN,
    ST_UMUL,
    ST_UDIV,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT,
    ST_ERR
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [5:0]  bin;
    logic [31:0] estimate;
    logic        last;
    logic        error;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic             load_k;
    logic             load_m;
    logic             load_p;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             copy;
    logic             copy_to_prev;
    logic             issue;
    logic             mode_upd;
    logic             clr;
    logic             div_start;
    logic             div_scale;
    logic             ratio_we;
    logic             est_we;
    logic             out_load;
    logic             out_last;
    logic             out_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_empty;
    logic acc_zero;
    logic eff_zero;
    logic div_busy;
    logic out_pend;
    logic out_taken;
    logic out_last;
  } sts_t;

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

@@ design/ibu_ram.sv @@
module ibu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ibu_div.sv @@
module ibu_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         scale_i,
  input  logic [95:0]  dividend_i,
  input  logic [63:0]  divisor_i,
  output logic         busy_o,
  output logic [63:0]  quot_o,
  output logic         sat_o
);
  import ibu_pkg::*;

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [95:0] dvd_q, dvd_d;
  logic [63:0] dsr_q, dsr_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quot_q, quot_d;
  logic        sat_q, sat_d;
  logic        scale_q, scale_d;
  logic [64:0] rem_sh;
  logic        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    sat_d   = sat_q;
    scale_d = scale_q;
    rem_sh  = {rem_q, dvd_q[95]};
    ge      = (rem_sh >= {1'b0, dsr_q});
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = 7'd95;
      dvd_d   = dividend_i;
      dsr_d   = divisor_i;
      rem_d   = '0;
      quot_d  = '0;
      sat_d   = 1'b0;
      scale_d = scale_i;
    end else if (busy_q) begin
      rem_d  = ge ? 64'(rem_sh - {1'b0, dsr_q}) : rem_sh[63:0];
      quot_d = {quot_q[62:0], ge};
      dvd_d  = {dvd_q[94:0], 1'b0};
      if (ge && scale_q && (cnt_q >= 7'd32)) begin
        sat_d = 1'b1;
      end
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    dvd_q   <= dvd_d;
    dsr_q   <= dsr_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    sat_q   <= sat_d;
    scale_q <= scale_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign sat_o  = sat_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_no_sat_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !scale_q) |-> !sat_q) else $error("saturation in ratio divide");
`endif

endmodule

@@ design/ibu_datapath.sv @@
module ibu_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ibu_pkg::req_t in_req_i,
  input  ibu_pkg::cmd_t cmd_i,
  output ibu_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ibu_pkg::rsp_t out_rsp_o
);
  import ibu_pkg::*;

  localparam int KAW = $clog2(K_DEPTH);

  logic [31:0] k_rdata, meas_rdata, prior_rdata, est_rdata, prev_rdata;
  logic [63:0] ratio_rdata;

  logic             cp_v_q;
  logic             cp_prev_q;
  logic [IDX_W-1:0] cp_addr_q;

  logic        v1_q, v2_q, v3_q;
  logic        md1_q, md2_q;
  logic [63:0] x1;
  logic [63:0] plo2_q, phi2_q;
  logic [31:0] k2_q, k3_q;
  logic [63:0] term3_d, term3_q;
  logic [63:0] acc_q;
  logic [EFF_W-1:0] eff_q;
  logic [63:0] m0_q, m1_q;

  logic [95:0] div_dvd;
  logic [63:0] div_dsr;
  logic        div_busy;
  logic [63:0] div_quot;
  logic        div_sat;
  logic [31:0] est_new;

  logic        est_we;
  logic [IDX_W-1:0] est_waddr;
  logic [31:0] est_wdata;

  logic        out_valid_q;
  rsp_t        out_q;

  // stores
  ibu_ram #(.WIDTH(32), .DEPTH(K_DEPTH)) u_resp (
    .clk_i, .we_i(cmd_i.load_k), .waddr_i(KAW'({in_req_i.row, in_req_i.col})),
    .wdata_i(in_req_i.value), .raddr_i({cmd_i.idx_a, cmd_i.idx_b}), .rdata_o(k_rdata)
  );

  ibu_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_meas (
    .clk_i, .we_i(cmd_i.load_m), .waddr_i(IDX_W'(in_req_i.row)),
    .wdata_i(in_req_i.value), .raddr_i(cmd_i.idx_a), .rdata_o(meas_rdata)
  );

  ibu_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_prior (
    .clk_i, .we_i(cmd_i.load_p), .waddr_i(IDX_W'(in_req_i.col)),
    .wdata_i(in_req_i.value), .raddr_i(cmd_i.idx_b), .rdata_o(prior_rdata)
  );

  assign est_new   = div_sat ? 32'hFFFF_FFFF : div_quot[31:0];
  assign est_we    = cmd_i.est_we | (cp_v_q & ~cp_prev_q);
  assign est_waddr = cmd_i.est_we ? cmd_i.idx_b : cp_addr_q;
  assign est_wdata = cmd_i.est_we ? est_new : prior_rdata;

  ibu_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_est (
    .clk_i, .we_i(est_we), .waddr_i(est_waddr),
    .wdata_i(est_wdata), .raddr_i(cmd_i.idx_b), .rdata_o(est_rdata)
  );

  ibu_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_prev (
    .clk_i, .we_i(cp_v_q & cp_prev_q), .waddr_i(cp_addr_q),
    .wdata_i(est_rdata), .raddr_i(cmd_i.idx_b), .rdata_o(prev_rdata)
  );

  ibu_ram #(.WIDTH(64), .DEPTH(MAX_BINS)) u_ratio (
    .clk_i, .we_i(cmd_i.ratio_we), .waddr_i(cmd_i.idx_a),
    .wdata_i(div_quot), .raddr_i(cmd_i.idx_a), .rdata_o(ratio_rdata)
  );

  // copy sweep: write in the cycle after the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_v_q <= 1'b0;
    end else begin
      cp_v_q <= cmd_i.copy;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_prev_q <= cmd_i.copy_to_prev;
    cp_addr_q <= cmd_i.idx_b;
  end

  // multiply-accumulate pipeline: read, multiply, scale, accumulate
  assign x1 = md1_q ? ratio_rdata : {32'b0, prev_rdata};

  always_comb begin
    if (md2_q) begin
      if (phi2_q[63:56] != 8'd0) begin
        term3_d = {64{1'b1}};
      end else begin
        term3_d = add_sat({phi2_q[55:0], 8'b0}, {24'b0, plo2_q[63:24]});
      end
    end else begin
      term3_d = {16'b0, plo2_q[63:16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    md1_q   <= cmd_i.mode_upd;
    md2_q   <= md1_q;
    plo2_q  <= k_rdata * x1[31:0];
    phi2_q  <= k_rdata * x1[63:32];
    k2_q    <= k_rdata;
    k3_q    <= k2_q;
    term3_q <= term3_d;
    m0_q    <= prev_rdata * acc_q[31:0];
    m1_q    <= prev_rdata * acc_q[63:32];
    if (cmd_i.clr) begin
      acc_q <= '0;
      eff_q <= '0;
    end else if (v3_q) begin
      acc_q <= add_sat(acc_q, term3_q);
      eff_q <= eff_q + EFF_W'(k3_q);
    end
  end

  // shared divider: folded ratio or scaled estimate
  assign div_dvd = cmd_i.div_scale ? ({m1_q, 32'b0} + {32'b0, m0_q})
                                   : {32'b0, meas_rdata, 32'b0};
  assign div_dsr = cmd_i.div_scale ? 64'(eff_q) : acc_q;

  ibu_div u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start), .scale_i(cmd_i.div_scale),
    .dividend_i(div_dvd), .divisor_i(div_dsr),
    .busy_o(div_busy), .quot_o(div_quot), .sat_o(div_sat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.bin      <= cmd_i.out_err ? 6'd0 : 6'(cmd_i.idx_b);
      out_q.estimate <= cmd_i.out_err ? 32'd0 : est_rdata;
      out_q.last     <= cmd_i.out_last;
      out_q.error    <= cmd_i.out_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign sts_o.pipe_empty = ~(v1_q | v2_q | v3_q);
  assign sts_o.acc_zero   = (acc_q == 64'd0);
  assign sts_o.eff_zero   = (eff_q == '0);
  assign sts_o.div_busy   = div_busy;
  assign sts_o.out_pend   = out_valid_q;
  assign sts_o.out_taken  = out_valid_q & ~out_stall_i;
  assign sts_o.out_last   = out_q.last;

`ifndef ASSERT_OFF
  a_no_double_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.est_we |-> !(cp_v_q && !cp_prev_q)) else $error("estimate write clash");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("stalled result dropped");
  a_div_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !(v1_q || v2_q || v3_q)) else $error("divide with pipe busy");
`endif

endmodule

@@ design/ibu_ctrl.sv @@
module ibu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ibu_pkg::func_e  in_func_i,
  output logic            in_stall_o,
  input  logic [7:0]      iterations_i,
  input  logic [6:0]      bins_i,
  input  ibu_pkg::sts_t   sts_i,
  output ibu_pkg::cmd_t   cmd_o
);
  import ibu_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] a_q, a_d, b_q, b_d, n_q, n_d;
  logic [7:0]       it_q, it_d, iters_q, iters_d;
  logic             take;
  logic             a_end, b_end;
  logic [CNT_W-1:0] n_sel;

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i & (state_q == ST_IDLE);
  assign a_end      = (a_q == n_q - CNT_W'(1));
  assign b_end      = (b_q == n_q - CNT_W'(1));

  // clamp the bin count to 1..MAX_BINS
  always_comb begin
    if (bins_i == 7'd0) begin
      n_sel = CNT_W'(1);
    end else if ({1'b0, bins_i} > 8'(MAX_BINS)) begin
      n_sel = CNT_W'(MAX_BINS);
    end else begin
      n_sel = CNT_W'(bins_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      n_q     <= CNT_W'(1);
      it_q    <= '0;
      iters_q <= '0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      n_q     <= n_d;
      it_q    <= it_d;
      iters_q <= iters_d;
    end
  end

  // take load requests; sequence a start request: init, then per pass copy, fold, update, then results
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    n_d     = n_q;
    it_d    = it_q;
    iters_d = iters_q;
    cmd_o   = '0;
    cmd_o.idx_a = a_q[IDX_W-1:0];
    cmd_o.idx_b = b_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (in_func_i)
            FUNC_RESP:  cmd_o.load_k = 1'b1;
            FUNC_MEAS:  cmd_o.load_m = 1'b1;
            FUNC_PRIOR: cmd_o.load_p = 1'b1;
            FUNC_START: begin
              n_d     = n_sel;
              iters_d = iterations_i;
              it_d    = '0;
              a_d     = '0;
              b_d     = '0;
              state_d = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        if (b_q == n_q) begin
          b_d     = '0;
          state_d = (iters_q == 8'd0) ? ST_OUT_RD : ST_COPY;
        end else begin
          cmd_o.copy = 1'b1;
          b_d        = b_q + CNT_W'(1);
        end
      end
      ST_COPY: begin
        if (b_q == n_q) begin
          a_d     = '0;
          b_d     = '0;
          state_d = ST_FOLD;
        end else begin
          cmd_o.copy         = 1'b1;
          cmd_o.copy_to_prev = 1'b1;
          b_d                = b_q + CNT_W'(1);
        end
      end
      ST_FOLD: begin
        cmd_o.issue = 1'b1;
        cmd_o.clr   = (b_q == '0);
        if (b_end) begin
          state_d = ST_FDRAIN;
        end else begin
          b_d = b_q + CNT_W'(1);
        end
      end
      ST_FDRAIN: begin
        if (sts_i.pipe_empty) begin
          if (sts_i.acc_zero) begin
            state_d = ST_ERR;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_FDIV;
          end
        end
      end
      ST_FDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.ratio_we = 1'b1;
          b_d            = '0;
          if (a_end) begin
            a_d     = '0;
            state_d = ST_UPD;
          end else begin
            a_d     = a_q + CNT_W'(1);
            state_d = ST_FOLD;
          end
        end
      end
      ST_UPD: begin
        cmd_o.issue    = 1'b1;
        cmd_o.mode_upd = 1'b1;
        cmd_o.clr      = (a_q == '0);
        if (a_end) begin
          state_d = ST_UDRAIN;
        end else begin
          a_d = a_q + CNT_W'(1);
        end
      end
      ST_UDRAIN: begin
        if (sts_i.pipe_empty) begin
          state_d = sts_i.eff_zero ? ST_ERR : ST_UMUL;
        end
      end
      ST_UMUL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_scale = 1'b1;
        state_d         = ST_UDIV;
      end
      ST_UDIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.est_we = 1'b1;
          a_d          = '0;
          if (b_end) begin
            b_d = '0;
            if ({1'b0, it_q} + 9'd1 == {1'b0, iters_q}) begin
              state_d = ST_OUT_RD;
            end else begin
              it_d    = it_q + 8'd1;
              state_d = ST_COPY;
            end
          end else begin
            b_d     = b_q + CNT_W'(1);
            state_d = ST_UPD;
          end
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = b_end;
        state_d        = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (sts_i.out_taken) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            b_d     = b_q + CNT_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_ERR: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = 1'b1;
        cmd_o.out_err  = 1'b1;
        state_d        = ST_OUT_WAIT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_pend) else $error("result overwritten");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy) else $error("divider restarted");
  a_copy_est: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.est_we |-> !cmd_o.copy) else $error("estimate write during copy");
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (sts_i.pipe_empty && !sts_i.div_busy))
    else $error("idle with work in flight");
`endif

endmodule

@@ design/iterative_bayesian_unfolding_top.sv @@
// Channel  Direction  Handshake              Payload
// in       request    in_valid_i/in_stall_o  in_req_i  (func, row, col, value)
// out      result     out_valid_o/out_stall_i out_rsp_o (bin, estimate, last, error)
// cfg      APB write  psel/penable/pwrite    paddr[2] selects iterations or bins_in_use
//
// Load requests are accepted back to back while no start request is in progress.
// A start request runs I iterations of the multiply-accumulate sweeps over n bins,
// each pass using the shared divider, then returns one result per bin (or 1 error result).
// Reset initialises control and the configuration registers only; stores hold nothing until written.
// in_stall_o is high from a start request until its last result is taken.
module iterative_bayesian_unfolding_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ibu_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ibu_pkg::rsp_t out_rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ibu_pkg::*;

  logic [7:0] iter_q;
  logic [6:0] bins_q;
  logic       cfg_we;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= ITER_RESET;
      bins_q <= BINS_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_ITERATIONS: iter_q <= pwdata[7:0];
        REG_BINS:       bins_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ITERATIONS: prdata = {24'b0, iter_q};
      REG_BINS:       prdata = {25'b0, bins_q};
      default:        prdata = '0;
    endcase
  end

  ibu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_func_i(in_req_i.func), .in_stall_o,
    .iterations_i(iter_q), .bins_i(bins_q),
    .sts_i(sts), .cmd_o(cmd)
  );

  ibu_datapath u_dp (
    .clk_i, .rst_ni,
    .in_req_i, .cmd_i(cmd), .sts_o(sts),
    .out_valid_o, .out_stall_i, .out_rsp_o
  );

endmodule

@@ verif/iterative_bayesian_unfolding_top_test.sv @@
module iterative_bayesian_unfolding_top_test;
  import ibu_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 450;

  typedef enum {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        reg_sel;
    logic [31:0] wdata;
    req_t        req;
    bit          typed;
    rsp_t        rsp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  req_t        in_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  rsp_t        out_rsp_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block's stores and registers
  logic [31:0] resp_k [MAX_BINS*MAX_BINS];
  logic [31:0] meas_b [MAX_BINS];
  logic [31:0] prior_p [MAX_BINS];
  bit          k_set [MAX_BINS*MAX_BINS];
  bit          m_set [MAX_BINS];
  bit          p_set [MAX_BINS];
  logic [7:0]  iter_cfg;
  logic [6:0]  bins_cfg;

  rsp_t        estimate_q [$];
  int          fail_cnt;
  int          cycle_cnt;
  int          burst_left;
  int          stall_mode;
  int          stall_left;
  int          req_cnt;
  dir_row_t    dir_tab [24];

  iterative_bayesian_unfolding_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // give up on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // run the unfolding passes and queue the estimates it should produce
  function automatic void unfold_run();
    int          n;
    logic [31:0] est [MAX_BINS];
    logic [31:0] prev [MAX_BINS];
    logic [63:0] ratio [MAX_BINS];
    logic [63:0] f;
    logic [63:0] eff;
    logic [63:0] s;
    logic [64:0] s2;
    logic [95:0] w;
    logic [95:0] q;
    logic [31:0] k;
    bit          bad;
    rsp_t        r;
    n = (bins_cfg == 0) ? 1 : ((bins_cfg > MAX_BINS) ? MAX_BINS : int'(bins_cfg));
    for (int j = 0; j < n; j++) est[j] = prior_p[j];
    bad = 0;
    for (int it = 0; it < int'(iter_cfg) && !bad; it++) begin
      prev = est;
      // fold the previous estimate
      for (int i = 0; i < n && !bad; i++) begin
        f = 0;
        for (int j = 0; j < n; j++)
          f += ({32'b0, resp_k[i*MAX_BINS+j]} * {32'b0, prev[j]}) >> 16;
        if (f == 0) bad = 1;
        else ratio[i] = {meas_b[i], 32'b0} / f;
      end
      // column efficiencies must all be nonzero
      for (int j = 0; j < n && !bad; j++) begin
        eff = 0;
        for (int i = 0; i < n; i++) eff += {32'b0, resp_k[i*MAX_BINS+j]};
        if (eff == 0) bad = 1;
      end
      // update each estimate bin
      for (int j = 0; j < n && !bad; j++) begin
        eff = 0;
        s = 0;
        for (int i = 0; i < n; i++) begin
          k = resp_k[i*MAX_BINS+j];
          eff += {32'b0, k};
          w = ({64'b0, k} * {32'b0, ratio[i]}) >> 24;
          s2 = {1'b0, s} + {1'b0, (|w[95:64]) ? {64{1'b1}} : w[63:0]};
          s = s2[64] ? {64{1'b1}} : s2[63:0];
        end
        q = ({64'b0, prev[j]} * {32'b0, s}) / {32'b0, eff};
        est[j] = (|q[95:32]) ? 32'hFFFFFFFF : q[31:0];
      end
    end
    if (bad) begin
      r = '{bin: 6'd0, estimate: 32'd0, last: 1'b1, error: 1'b1};
      estimate_q.push_back(r);
    end else begin
      for (int j = 0; j < n; j++) begin
        r = '{bin: 6'(j), estimate: est[j], last: (j == n - 1), error: 1'b0};
        estimate_q.push_back(r);
      end
    end
  endfunction

  // book an accepted request into the shadow state
  function automatic void take_request(input req_t r, input bit typed, input rsp_t t);
    int qlen;
    case (r.func)
      FUNC_RESP: begin
        resp_k[r.row*MAX_BINS+r.col] = r.value;
        k_set[r.row*MAX_BINS+r.col] = 1;
      end
      FUNC_MEAS: begin
        meas_b[r.row] = r.value;
        m_set[r.row] = 1;
      end
      FUNC_PRIOR: begin
        prior_p[r.col] = r.value;
        p_set[r.col] = 1;
      end
      default: begin
        qlen = estimate_q.size();
        unfold_run();
        if (typed) begin
          while (estimate_q.size() > qlen) void'(estimate_q.pop_back());
          estimate_q.push_back(t);
        end
      end
    endcase
  endfunction

  // present one request in bursts with random gaps and hold until taken
  task automatic send_request(input req_t r, input bit typed = 0, input rsp_t t = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    take_request(r, typed, t);
    req_cnt++;
  endtask

  // drop valid and hold until every expected estimate has drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic sel, input logic [31:0] data);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_ITERATIONS) iter_cfg = data[7:0];
    else bins_cfg = data[6:0];
  endtask

  function automatic logic [31:0] rand_resp();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFFFFFF;
      2:       return $urandom();
      default: return $urandom_range(32'h00100000, 32'h02000000);
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFFFFFF;
      2:       return $urandom();
      default: return $urandom_range(1, 32'h00100000);
    endcase
  endfunction

  function automatic req_t mk_req(input func_e f, input int row, input int col,
                                  input logic [31:0] v);
    req_t r;
    r.func  = f;
    r.row   = 6'(row);
    r.col   = 6'(col);
    r.value = v;
    return r;
  endfunction

  // load what a run of the current size needs, then start it
  task automatic run_sequence(input bit broken);
    int n;
    int zc;
    n = (bins_cfg == 0) ? 1 : ((bins_cfg > MAX_BINS) ? MAX_BINS : int'(bins_cfg));
    zc = $urandom_range(0, n - 1);
    for (int c = 0; c < n; c++)
      if (!p_set[c] || $urandom_range(0, 2) == 0)
        send_request(mk_req(FUNC_PRIOR, $urandom_range(0, 63), c, rand_count()));
    if (iter_cfg != 0) begin
      for (int i = 0; i < n; i++) begin
        if (!m_set[i] || $urandom_range(0, 2) == 0)
          send_request(mk_req(FUNC_MEAS, i, $urandom_range(0, 63), rand_count()));
        for (int j = 0; j < n; j++)
          if (!k_set[i*MAX_BINS+j] || $urandom_range(0, 2) == 0)
            send_request(mk_req(FUNC_RESP, i, j, rand_resp()));
      end
      // zero a response column, or the whole prior
      if (broken) begin
        if ($urandom_range(0, 1) == 0)
          for (int i = 0; i < n; i++) send_request(mk_req(FUNC_RESP, i, zc, 32'd0));
        else
          for (int c = 0; c < n; c++) send_request(mk_req(FUNC_PRIOR, 0, c, 32'd0));
      end
    end
    send_request(mk_req(FUNC_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom()));
  endtask

  // check results against the oldest expectation; stall on a pattern
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (estimate_q.size() == 0) begin
          $error("unexpected result bin=%0d estimate=%h", out_rsp_o.bin, out_rsp_o.estimate);
          fail_cnt++;
        end else begin
          e = estimate_q.pop_front();
          if (out_rsp_o.bin !== e.bin) begin
            $error("bin: expected %0d, got %0d", e.bin, out_rsp_o.bin);
            fail_cnt++;
          end
          if (out_rsp_o.estimate !== e.estimate) begin
            $error("estimate: expected %h, got %h", e.estimate, out_rsp_o.estimate);
            fail_cnt++;
          end
          if (out_rsp_o.last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, out_rsp_o.last);
            fail_cnt++;
          end
          if (out_rsp_o.error !== e.error) begin
            $error("error: expected %0b, got %0b", e.error, out_rsp_o.error);
            fail_cnt++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(5, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  initial begin
    rsp_t sat_one;
    rsp_t err_one;
    sat_one = '{bin: 6'd0, estimate: 32'hFFFFFFFF, last: 1'b1, error: 1'b0};
    err_one = '{bin: 6'd0, estimate: 32'd0, last: 1'b1, error: 1'b1};
    dir_tab = '{
      '{ROW_CFG, REG_ITERATIONS, 32'd0,   '0, 0, '0},
      '{ROW_CFG, REG_BINS,       32'd1,   '0, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_PRIOR, 6'd0, 6'd0, 32'hFFFFFFFF}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_START, 6'd0, 6'd0, 32'd0},  1, sat_one},
      '{ROW_CFG, REG_BINS,       32'd0,   '0, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_START, 6'd63, 6'd63, 32'hFFFFFFFF}, 1, sat_one},
      '{ROW_CFG, REG_ITERATIONS, 32'd1,   '0, 0, '0},
      '{ROW_CFG, REG_BINS,       32'd2,   '0, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_RESP,  6'd0, 6'd0, 32'h01000000}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_RESP,  6'd0, 6'd1, 32'd0}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_RESP,  6'd1, 6'd0, 32'd0}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_RESP,  6'd1, 6'd1, 32'h01000000}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_MEAS,  6'd0, 6'd0, 32'h00000100}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_MEAS,  6'd1, 6'd0, 32'hFFFFFFFF}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_PRIOR, 6'd0, 6'd0, 32'h00000100}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_PRIOR, 6'd0, 6'd1, 32'h00000100}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_START, 6'd0, 6'd0, 32'd0}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_RESP,  6'd1, 6'd1, 32'd0}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_START, 6'd0, 6'd0, 32'd0}, 1, err_one},
      '{ROW_CFG, REG_ITERATIONS, 32'd255, '0, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_RESP,  6'd1, 6'd1, 32'hFFFFFFFF}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_START, 6'd0, 6'd0, 32'd0}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_PRIOR, 6'd0, 6'd1, 32'd0}, 0, '0},
      '{ROW_REQ, 1'b0, 32'd0, '{FUNC_START, 6'd0, 6'd0, 32'd0}, 1, err_one}
    };

    // drive everything known, hold reset
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cycle_cnt   = 0;
    fail_cnt    = 0;
    burst_left  = 0;
    req_cnt     = 0;
    iter_cfg    = ITER_RESET;
    bins_cfg    = BINS_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) reg_write(dir_tab[r].reg_sel, dir_tab[r].wdata);
      else send_request(dir_tab[r].req, dir_tab[r].typed, dir_tab[r].rsp);
    end

    // random traffic, with one full-width phase partway through
    req_cnt = 0;
    while (req_cnt < RANDOM_ITEMS) begin
      if (req_cnt > 200 && !p_set[MAX_BINS-1]) begin
        for (int c = 0; c < MAX_BINS; c++)
          send_request(mk_req(FUNC_PRIOR, $urandom_range(0, 63), c, $urandom()));
        reg_write(REG_ITERATIONS, 32'd0);
        reg_write(REG_BINS, 32'd127);
        send_request(mk_req(FUNC_START, 0, 0, 0));
        reg_write(REG_BINS, 32'd64);
        send_request(mk_req(FUNC_START, 0, 0, 0));
        reg_write(REG_BINS, 32'd3);
      end
      if ($urandom_range(0, 7) == 0) begin
        reg_write(REG_ITERATIONS, ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10)
                                                              : $urandom_range(0, 3));
        reg_write(REG_BINS, ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14)
                                                        : $urandom_range(1, 8));
      end
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 6))
            send_request(mk_req(func_e'($urandom_range(0, 2)), $urandom_range(0, 63),
                                $urandom_range(0, 63), $urandom()));
        end
        3, 4:    run_sequence(1);
        default: run_sequence(0);
      endcase
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && estimate_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
